FILE: rtl/fam_pkg.sv
// Shared opcode type and constants for the fraction arithmetic block.
package fam_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_e;

  // Width used to sign the result fields before they are cut to their port widths.
  localparam int ExtW = 65;

  localparam int WholeW  = 32;
  localparam int RemNumW = 32;
  localparam int RemDenW = 31;

endpackage

FILE: rtl/fam_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module fam_mul #(
  parameter int W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);

  localparam int CntW = $clog2(W + 1);

  logic [2*W-1:0] a_q;
  logic [W-1:0]   b_q;
  logic [2*W-1:0] acc_q;
  logic [CntW-1:0] cnt_q;
  logic           busy_q;
  logic           done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= {{W{1'b0}}, a_i};
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[2*W-2:0], 1'b0};
      b_q <= {1'b0, b_q[W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: rtl/fam_div.sv
// Restoring unsigned divider producing one quotient bit per cycle.
module fam_div #(
  parameter int N = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dvd_i,
  input  logic [N-1:0] dvs_i,
  output logic         done_o,
  output logic [N-1:0] quo_o,
  output logic [N-1:0] rem_o
);

  localparam int CntW = $clog2(N + 1);

  logic [N-1:0]    q_q;
  logic [N-1:0]    r_q;
  logic [N-1:0]    d_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [N:0]      rs;
  logic [N:0]      diff;
  logic            ge;

  assign rs   = {r_q, q_q[N-1]};
  assign ge   = rs >= {1'b0, d_q};
  assign diff = rs - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(N);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dvd_i;
      r_q <= '0;
      d_q <= dvs_i;
    end else if (busy_q) begin
      r_q <= ge ? diff[N-1:0] : rs[N-1:0];
      q_q <= {q_q[N-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
  assign rem_o  = r_q;

endmodule

FILE: rtl/fam_gcd.sv
// Binary GCD of two nonzero values that are not both even, one step per cycle.
module fam_gcd #(
  parameter int N = 30
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] u_i,
  input  logic [N-1:0] v_i,
  output logic         done_o,
  output logic [N-1:0] g_o
);

  logic [N-1:0] u_q;
  logic [N-1:0] v_q;
  logic         busy_q;
  logic         done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (u_q == v_q)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= u_i;
      v_q <= v_i;
    end else if (busy_q && (u_q != v_q)) begin
      if (!u_q[0]) begin
        u_q <= {1'b0, u_q[N-1:1]};
      end else if (!v_q[0]) begin
        v_q <= {1'b0, v_q[N-1:1]};
      end else if (u_q > v_q) begin
        u_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
  end

  assign done_o = done_q;
  assign g_o    = u_q;

endmodule

FILE: rtl/fraction_arith_mixed_number.sv
// Top level of the fraction arithmetic block with mixed-number result.
// Each transaction combines two signed fractions with add, subtract, multiply or divide
// and returns the whole part and the reduced remainder fraction, or an error flag with
// zero fields for a zero denominator or a zero divisor. One transaction is processed at
// a time. Each transaction runs serial multiplications, two for multiply and divide and
// three for add and subtract, then forms the signed sum and divides it by the last
// product in the restoring divider. When the remainder is nonzero, common factors
// of two are stripped, binary GCD steps find the common divisor and a second pair of
// divisions does the reduction; the result is then moved to the output register. An
// error transaction goes straight to the output register stage. The next transaction
// is accepted as soon as the result is moved to the output register, even if it has
// not yet been taken.
module fraction_arith_mixed_number
  import fam_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_num_i,
  input  logic [OPERAND_WIDTH-2:0]   a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_num_i,
  input  logic [OPERAND_WIDTH-2:0]   b_den_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       error_o,
  output logic signed [WholeW-1:0]   whole_part_o,
  output logic signed [RemNumW-1:0]  rem_num_o,
  output logic [RemDenW-1:0]         rem_den_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int DW = 2 * W - 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SUM,
    ST_DIV,
    ST_EVEN,
    ST_GCD,
    ST_RED,
    ST_FIN
  } state_e;

  state_e        state_q;
  opcode_e       op_q;
  logic          sa_q, sb_q, eq_q, err_q, neg_q;
  logic [W-1:0]  ma_q, mb_q;
  logic [W-2:0]  ad_q, bd_q;
  logic [MW-1:0] p1_q, p2_q, mag_q, whole_q;
  logic [DW-1:0] den_q, rem_q;
  logic          mul_start_q, div_start_q, gcd_start_q;

  logic          out_valid_q, out_err_q;
  logic [WholeW-1:0]  out_whole_q;
  logic [RemNumW-1:0] out_rem_q;
  logic [RemDenW-1:0] out_den_q;

  logic          in_err;
  logic          addsub;
  logic [W-1:0]  one_w;
  logic [W-1:0]  mop_a, mop_b;
  logic          mul_done;
  logic [MW-1:0] mul_prod;
  logic [MW-1:0] da_dvd, da_dvs, db_dvd, db_dvs;
  logic          da_done, db_done, gcd_done;
  logic [MW-1:0] da_quo, da_rem, db_quo, db_rem;
  logic [DW-1:0] gcd_g;
  logic [MW:0]   sx, sy, ssum, sabs;
  logic          sum_neg;
  logic [MW-1:0] sum_mag;
  logic [ExtW-1:0] whole_x, rem_x, den_x, whole_s, rem_s;
  logic          wneg, rneg;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_err = (a_den_i == '0) || (b_den_i == '0)
                  || ((opcode_i == OP_DIV) && (b_num_i == '0));
  assign addsub = (op_q == OP_ADD) || (op_q == OP_SUB);
  assign one_w  = W'(1);

  always_comb begin
    unique case (state_q)
      ST_MUL1: begin
        mop_a = ma_q;
        mop_b = (op_q == OP_MUL) ? mb_q : ((addsub && eq_q) ? one_w : {1'b0, bd_q});
      end
      ST_MUL2: begin
        mop_a = mb_q;
        mop_b = eq_q ? one_w : {1'b0, ad_q};
      end
      default: begin
        mop_a = {1'b0, ad_q};
        mop_b = (op_q == OP_DIV) ? mb_q : ((addsub && eq_q) ? one_w : {1'b0, bd_q});
      end
    endcase
  end

  fam_mul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mop_a),
    .b_i     (mop_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign da_dvd = (state_q == ST_RED) ? {2'b00, rem_q} : mag_q;
  assign da_dvs = (state_q == ST_RED) ? {2'b00, gcd_g} : {2'b00, den_q};
  assign db_dvd = {2'b00, den_q};
  assign db_dvs = {2'b00, gcd_g};

  fam_div #(.N(MW)) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .dvd_i   (da_dvd),
    .dvs_i   (da_dvs),
    .done_o  (da_done),
    .quo_o   (da_quo),
    .rem_o   (da_rem)
  );

  fam_div #(.N(MW)) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q && (state_q == ST_RED)),
    .dvd_i   (db_dvd),
    .dvs_i   (db_dvs),
    .done_o  (db_done),
    .quo_o   (db_quo),
    .rem_o   (db_rem)
  );

  fam_gcd #(.N(DW)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start_q),
    .u_i     (den_q),
    .v_i     (rem_q),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  assign sx   = {1'b0, p1_q};
  assign sy   = {1'b0, p2_q};
  assign ssum = (sa_q ? -sx : sx) + (((op_q == OP_SUB) ^ sb_q) ? -sy : sy);
  assign sabs = ssum[MW] ? -ssum : ssum;

  always_comb begin
    if (addsub) begin
      sum_neg = ssum[MW];
      sum_mag = sabs[MW-1:0];
    end else begin
      sum_neg = (sa_q ^ sb_q) && (p1_q != '0);
      sum_mag = p1_q;
    end
  end

  assign whole_x = {{(ExtW - MW){1'b0}}, whole_q};
  assign rem_x   = {{(ExtW - DW){1'b0}}, rem_q};
  assign den_x   = {{(ExtW - DW){1'b0}}, den_q};
  assign wneg    = neg_q && (whole_q != '0);
  assign rneg    = neg_q && (whole_q == '0);
  assign whole_s = wneg ? -whole_x : whole_x;
  assign rem_s   = rneg ? -rem_x : rem_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      gcd_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      gcd_start_q <= 1'b0;
      if ((state_q == ST_FIN) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (in_err) begin
              state_q <= ST_FIN;
            end else begin
              state_q     <= ST_MUL1;
              mul_start_q <= 1'b1;
            end
          end
        end
        ST_MUL1: begin
          if (mul_done) begin
            mul_start_q <= 1'b1;
            state_q     <= addsub ? ST_MUL2 : ST_MUL3;
          end
        end
        ST_MUL2: begin
          if (mul_done) begin
            mul_start_q <= 1'b1;
            state_q     <= ST_MUL3;
          end
        end
        ST_MUL3: begin
          if (mul_done) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          div_start_q <= 1'b1;
          state_q     <= ST_DIV;
        end
        ST_DIV: begin
          if (da_done) begin
            state_q <= (da_rem == '0) ? ST_FIN : ST_EVEN;
          end
        end
        ST_EVEN: begin
          if (rem_q[0] || den_q[0]) begin
            gcd_start_q <= 1'b1;
            state_q     <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (gcd_done) begin
            div_start_q <= 1'b1;
            state_q     <= ST_RED;
          end
        end
        ST_RED: begin
          if (da_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_q  <= opcode_e'(opcode_i);
          err_q <= in_err;
          sa_q  <= a_num_i[W-1];
          sb_q  <= b_num_i[W-1];
          ma_q  <= a_num_i[W-1] ? -a_num_i : a_num_i;
          mb_q  <= b_num_i[W-1] ? -b_num_i : b_num_i;
          ad_q  <= a_den_i;
          bd_q  <= b_den_i;
          eq_q  <= (a_den_i == b_den_i);
        end
      end
      ST_MUL1: begin
        if (mul_done) begin
          p1_q <= mul_prod;
        end
      end
      ST_MUL2: begin
        if (mul_done) begin
          p2_q <= mul_prod;
        end
      end
      ST_MUL3: begin
        if (mul_done) begin
          den_q <= mul_prod[DW-1:0];
        end
      end
      ST_SUM: begin
        neg_q <= sum_neg;
        mag_q <= sum_mag;
      end
      ST_DIV: begin
        if (da_done) begin
          whole_q <= da_quo;
          rem_q   <= da_rem[DW-1:0];
        end
      end
      ST_EVEN: begin
        if (!rem_q[0] && !den_q[0]) begin
          rem_q <= {1'b0, rem_q[DW-1:1]};
          den_q <= {1'b0, den_q[DW-1:1]};
        end
      end
      ST_RED: begin
        if (da_done) begin
          rem_q <= da_quo[DW-1:0];
          den_q <= db_quo[DW-1:0];
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_err_q   <= err_q;
          out_whole_q <= err_q ? '0 : whole_s[WholeW-1:0];
          out_rem_q   <= err_q ? '0 : rem_s[RemNumW-1:0];
          out_den_q   <= err_q ? '0 : den_x[RemDenW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign error_o      = out_err_q;
  assign whole_part_o = out_whole_q;
  assign rem_num_o    = out_rem_q;
  assign rem_den_o    = out_den_q;

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("Accepted transaction did not start processing.");

  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> ((state_q == ST_MUL1) || (state_q == ST_MUL2) || (state_q == ST_MUL3)))
    else $error("Multiplier finished outside a multiply step.");

  a_gcd_done_in_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_done |-> (state_q == ST_GCD))
    else $error("GCD unit finished outside the GCD step.");

  a_div_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (db_done && (state_q == ST_RED)) |-> (da_done && (db_rem == '0)))
    else $error("Reduction dividers finished out of step or inexactly.");
`endif

endmodule
